// ===== hw/rtl/kaa_pkg.sv =====
package kaa_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS = 16;
  localparam int CI_W = $clog2(MAX_CLUSTERS);
  localparam int DI_W = $clog2(MAX_DIMS);
  localparam int ADDR_W = CI_W + DI_W;
  localparam int CFG_W = 5;
  localparam int VAL_W = 16;
  localparam int DIST_W = 36;
  localparam int TOT_W = 64;
  localparam int SUM_W = 48;
  localparam int CNT_W = 32;

  localparam logic [1:0] KIND_CWR = 2'd0;
  localparam logic [1:0] KIND_PT = 2'd1;
  localparam logic [1:0] KIND_CLR = 2'd2;
  localparam logic [1:0] KIND_RD = 2'd3;

  localparam logic CFG_NUM_CLUSTERS = 1'b0;
  localparam logic CFG_NUM_DIMS = 1'b1;

  localparam logic RES_ASSIGN = 1'b0;
  localparam logic RES_READ = 1'b1;

  typedef enum logic [2:0] {
    OP_CWR,
    OP_PWR,
    OP_PSRCH,
    OP_CLR,
    OP_RD
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [CI_W-1:0]         ci;
    logic [DI_W-1:0]         di;
    logic signed [VAL_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic                    rkind;
    logic [CI_W-1:0]         nearest;
    logic [DIST_W-1:0]       min_d;
    logic [TOT_W-1:0]        tot_d;
    logic [TOT_W-1:0]        tot_sse;
    logic signed [SUM_W-1:0] csum;
    logic [CNT_W-1:0]        cnt;
  } res_t;

  function automatic logic [CFG_W-1:0] eff_limit(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] mx);
    logic [CFG_W-1:0] r;
    r = v;
    if (r == '0) r = CFG_W'(1);
    if (r > mx) r = mx;
    return r;
  endfunction

endpackage

// ===== hw/rtl/kaa_front.sv =====
module kaa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind,
  input  logic [kaa_pkg::CI_W-1:0]     ci,
  input  logic [kaa_pkg::DI_W-1:0]     di,
  input  logic signed [kaa_pkg::VAL_W-1:0] val,
  input  logic [kaa_pkg::CFG_W-1:0]    nd,
  output logic                         cmd_valid,
  output kaa_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);

  kaa_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  kaa_pkg::cmd_t dec;
  logic          wr, rd;

  always_comb begin
    dec.ci = ci;
    dec.di = di;
    dec.val = val;
    unique case (kind)
      kaa_pkg::KIND_CWR: dec.op = kaa_pkg::OP_CWR;
      kaa_pkg::KIND_PT: begin
        if ({1'b0, di} == nd - kaa_pkg::CFG_W'(1)) dec.op = kaa_pkg::OP_PSRCH;
        else dec.op = kaa_pkg::OP_PWR;
      end
      kaa_pkg::KIND_CLR: dec.op = kaa_pkg::OP_CLR;
      default: dec.op = kaa_pkg::OP_RD;
    endcase
  end

  assign full = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];
  assign wr = push && !full;
  assign rd = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= dec;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== hw/rtl/kaa_back.sv =====
module kaa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  kaa_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic [kaa_pkg::CFG_W-1:0] nc,
  input  logic [kaa_pkg::CFG_W-1:0] nd,
  output logic                      res_valid,
  input  logic                      res_ready,
  output kaa_pkg::res_t             res
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_DRAIN, S_TOT, S_SQ, S_UPD, S_UPDW, S_RD, S_OUT
  } state_t;

  localparam int CW = kaa_pkg::CI_W;
  localparam int DW = kaa_pkg::DI_W;
  localparam int AW = kaa_pkg::ADDR_W;
  localparam int NE = kaa_pkg::MAX_CLUSTERS * kaa_pkg::MAX_DIMS;

  state_t state_r;

  logic signed [kaa_pkg::VAL_W-1:0] cent_mem [NE];
  logic signed [kaa_pkg::SUM_W-1:0] sum_mem [NE];
  logic signed [kaa_pkg::VAL_W-1:0] pt_r [kaa_pkg::MAX_DIMS];
  logic [NE-1:0]                    sum_vld_r;
  logic [kaa_pkg::CNT_W-1:0]        cnt_r [kaa_pkg::MAX_CLUSTERS];
  logic [kaa_pkg::TOT_W-1:0]        tot_d_r, tot_sse_r;

  logic [CW-1:0] k_r;
  logic [DW-1:0] j_r;
  logic [CW-1:0] ci_r;
  logic [DW-1:0] di_r;

  logic signed [kaa_pkg::VAL_W-1:0] c_q_r, p_q_r;
  logic          s1_v_r, s1_first_r, s1_last_r;
  logic [CW-1:0] s1_k_r;
  logic [2*kaa_pkg::VAL_W+1:0] sq_r;
  logic          s2_v_r, s2_first_r, s2_last_r;
  logic [CW-1:0] s2_k_r;
  logic [kaa_pkg::DIST_W-1:0] acc_r, best_d_r;
  logic [CW-1:0] best_r;
  logic          best_set_r;
  logic [2*kaa_pkg::TOT_W/2-1:0] prod_r;

  logic          u_v_r;
  logic [DW-1:0] u_j_r;
  logic signed [kaa_pkg::VAL_W-1:0] u_pt_r;
  logic signed [kaa_pkg::SUM_W-1:0] sum_rd_r;

  kaa_pkg::res_t res_r;

  logic          mem_wr;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] c_raddr;
  logic [AW-1:0] s_raddr;
  logic          s_wr;
  logic [AW-1:0] s_waddr;
  logic signed [kaa_pkg::SUM_W-1:0] s_wdata;
  logic signed [kaa_pkg::SUM_W-1:0] s_old;
  logic signed [kaa_pkg::SUM_W:0]   s_add;
  logic signed [kaa_pkg::VAL_W:0]   diff;
  logic signed [2*kaa_pkg::VAL_W+1:0] sq_s;
  logic [kaa_pkg::DIST_W-1:0] acc_new;
  logic          j_last, k_last;
  logic [kaa_pkg::TOT_W:0] d_add, e_add;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = (state_r == S_OUT);
  assign res = res_r;

  assign mem_wr = cmd_pop && (cmd.op == kaa_pkg::OP_CWR);
  assign mem_waddr = {cmd.ci, cmd.di};
  assign c_raddr = {k_r, j_r};
  assign s_raddr = (state_r == S_IDLE) ? {cmd.ci, cmd.di} : {best_r, j_r};
  assign s_wr = u_v_r;
  assign s_waddr = {best_r, u_j_r};
  assign s_old = sum_vld_r[s_waddr] ? sum_rd_r : '0;
  assign s_add = {s_old[kaa_pkg::SUM_W-1], s_old} + (kaa_pkg::SUM_W+1)'(u_pt_r);

  always_comb begin
    if (s_add[kaa_pkg::SUM_W] != s_add[kaa_pkg::SUM_W-1]) begin
      s_wdata = s_add[kaa_pkg::SUM_W] ? {1'b1, {(kaa_pkg::SUM_W-1){1'b0}}}
                                      : {1'b0, {(kaa_pkg::SUM_W-1){1'b1}}};
    end else begin
      s_wdata = s_add[kaa_pkg::SUM_W-1:0];
    end
  end

  assign diff = {p_q_r[kaa_pkg::VAL_W-1], p_q_r} - {c_q_r[kaa_pkg::VAL_W-1], c_q_r};
  assign sq_s = diff * diff;
  assign acc_new = (s2_first_r ? '0 : acc_r) + kaa_pkg::DIST_W'(sq_r);
  assign j_last = ({1'b0, j_r} == nd - kaa_pkg::CFG_W'(1));
  assign k_last = ({1'b0, k_r} == nc - kaa_pkg::CFG_W'(1));
  assign d_add = {1'b0, tot_d_r} + (kaa_pkg::TOT_W+1)'(best_d_r);
  assign e_add = {1'b0, tot_sse_r} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (mem_wr) cent_mem[mem_waddr] <= cmd.val;
    c_q_r <= cent_mem[c_raddr];
    if (s_wr) sum_mem[s_waddr] <= s_wdata;
    sum_rd_r <= sum_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_vld_r <= '0;
      for (int i = 0; i < kaa_pkg::MAX_CLUSTERS; i++) cnt_r[i] <= '0;
      tot_d_r <= '0;
      tot_sse_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      u_v_r <= 1'b0;
    end else begin
      p_q_r <= pt_r[j_r];
      s1_v_r <= (state_r == S_SRCH);
      s1_first_r <= (j_r == '0);
      s1_last_r <= j_last;
      s1_k_r <= k_r;
      sq_r <= $unsigned(sq_s);
      s2_v_r <= s1_v_r;
      s2_first_r <= s1_first_r;
      s2_last_r <= s1_last_r;
      s2_k_r <= s1_k_r;
      if (s2_v_r) begin
        acc_r <= acc_new;
        if (s2_last_r && (!best_set_r || acc_new < best_d_r)) begin
          best_d_r <= acc_new;
          best_r <= s2_k_r;
          best_set_r <= 1'b1;
        end
      end
      u_v_r <= (state_r == S_UPD);
      u_j_r <= j_r;
      u_pt_r <= pt_r[j_r];
      if (s_wr) sum_vld_r[s_waddr] <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            ci_r <= cmd.ci;
            di_r <= cmd.di;
            k_r <= '0;
            j_r <= '0;
            best_set_r <= 1'b0;
            unique case (cmd.op)
              kaa_pkg::OP_PWR: pt_r[cmd.di] <= cmd.val;
              kaa_pkg::OP_PSRCH: begin
                pt_r[cmd.di] <= cmd.val;
                state_r <= S_SRCH;
              end
              kaa_pkg::OP_CLR: begin
                sum_vld_r <= '0;
                for (int i = 0; i < kaa_pkg::MAX_CLUSTERS; i++) cnt_r[i] <= '0;
                tot_d_r <= '0;
                tot_sse_r <= '0;
              end
              kaa_pkg::OP_RD: state_r <= S_RD;
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (j_last) begin
            j_r <= '0;
            k_r <= k_r + CW'(1);
            if (k_last) state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + DW'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r) state_r <= S_TOT;
        end
        S_TOT: begin
          tot_d_r <= d_add[kaa_pkg::TOT_W] ? '1 : d_add[kaa_pkg::TOT_W-1:0];
          prod_r <= (best_d_r[kaa_pkg::DIST_W-1:32] != '0) ? '1
                    : best_d_r[31:0] * best_d_r[31:0];
          state_r <= S_SQ;
        end
        S_SQ: begin
          tot_sse_r <= e_add[kaa_pkg::TOT_W] ? '1 : e_add[kaa_pkg::TOT_W-1:0];
          if (cnt_r[best_r] != '1) cnt_r[best_r] <= cnt_r[best_r] + kaa_pkg::CNT_W'(1);
          j_r <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          j_r <= j_r + DW'(1);
          if (j_last) state_r <= S_UPDW;
        end
        S_UPDW: begin
          if (!u_v_r) begin
            res_r.rkind <= kaa_pkg::RES_ASSIGN;
            res_r.nearest <= best_r;
            res_r.min_d <= best_d_r;
            res_r.tot_d <= tot_d_r;
            res_r.tot_sse <= tot_sse_r;
            res_r.csum <= '0;
            res_r.cnt <= '0;
            state_r <= S_OUT;
          end
        end
        S_RD: begin
          res_r.rkind <= kaa_pkg::RES_READ;
          res_r.nearest <= '0;
          res_r.min_d <= '0;
          res_r.tot_d <= tot_d_r;
          res_r.tot_sse <= tot_sse_r;
          res_r.csum <= sum_vld_r[{ci_r, di_r}] ? sum_rd_r : '0;
          res_r.cnt <= cnt_r[ci_r];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_r))
    else $error("result changed while stalled");
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TOT |-> !s1_v_r && !s2_v_r && best_set_r)
    else $error("totals updated before search finished");
  a_upd: assert property (@(posedge clk) disable iff (!rst_n)
    u_v_r |-> state_r == S_UPD || state_r == S_UPDW)
    else $error("sum write outside update");

endmodule

// ===== hw/rtl/kmeans_assign_accumulate.sv =====
// K-means assignment step in Q8.8 fixed point.
// Input items are pushed with in_push while in_full is low. Kind 0 writes a
// centroid coordinate, kind 1 stores a point coordinate, kind 2 clears the
// accumulators and kind 3 reads one coordinate sum, count and both totals.
// The point coordinate with index num_dims-1 starts a nearest-centroid search.
// Results appear while out_empty is low and are taken with out_pop.
// Items go through a two-entry command queue to the execution unit.
// Writes and clears complete as the item is taken; a read goes through the
// S_RD state and the result register to the output register.
// A search runs one multiply-accumulate per cycle through a three-stage pipe
// on the centroid memory port, then updates the totals, the count and the
// coordinate sums of the nearest cluster. The execution unit takes no new
// item until its result has moved on to the output register.
// Reset clears the registers (both limits to 1), totals, counts and sum
// valid bits; centroids and the point buffer are undefined until written.
// When the receiver stalls, one result waits in the output register, a
// second waits in the execution unit, and then the queue fills and in_full
// rises.
module kmeans_assign_accumulate (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [1:0]                            in_kind,
  input  logic [3:0]                            in_cluster_index,
  input  logic [3:0]                            in_coord_index,
  input  logic signed [15:0]                    in_coord_value,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic                                  out_result_kind,
  output logic [3:0]                            out_nearest_cluster,
  output logic [35:0]                           out_min_distance,
  output logic [63:0]                           out_total_distance,
  output logic [63:0]                           out_total_sse,
  output logic signed [47:0]                    out_coord_sum,
  output logic [31:0]                           out_cluster_count,
  input  logic                                  cfg_we,
  input  logic                                  cfg_addr,
  input  logic [4:0]                            cfg_wdata
);

  logic [kaa_pkg::CFG_W-1:0] ncl_r, ndm_r, nc, nd;
  logic          cmd_valid, cmd_pop, res_valid, res_ready, out_v_r;
  kaa_pkg::cmd_t cmd;
  kaa_pkg::res_t res, out_r;

  assign nc = kaa_pkg::eff_limit(ncl_r, kaa_pkg::CFG_W'(kaa_pkg::MAX_CLUSTERS));
  assign nd = kaa_pkg::eff_limit(ndm_r, kaa_pkg::CFG_W'(kaa_pkg::MAX_DIMS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r <= kaa_pkg::CFG_W'(1);
      ndm_r <= kaa_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kaa_pkg::CFG_NUM_CLUSTERS: ncl_r <= cfg_wdata;
        default: ndm_r <= cfg_wdata;
      endcase
    end
  end

  kaa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .kind     (in_kind),
    .ci       (in_cluster_index),
    .di       (in_coord_index),
    .val      (in_coord_value),
    .nd       (nd),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  kaa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .nc       (nc),
    .nd       (nd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_v_r || out_pop;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_r <= res;
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end

  assign out_empty = !out_v_r;
  assign out_result_kind = out_r.rkind;
  assign out_nearest_cluster = out_r.nearest;
  assign out_min_distance = out_r.min_d;
  assign out_total_distance = out_r.tot_d;
  assign out_total_sse = out_r.tot_sse;
  assign out_coord_sum = out_r.csum;
  assign out_cluster_count = out_r.cnt;

endmodule
